// ===== rtl/cansd_pkg.sv =====
// Shared types and constants for the CAN signal decoder.
// Used by every module of the block; no dependencies of its own.
`default_nettype none

package cansd_pkg;

  // Payload geometry
  localparam int PAYLOAD_BYTES = 8;
  localparam int PAYLOAD_BITS  = PAYLOAD_BYTES * 8;

  // Zero filter count used when the configured count is zero
  localparam logic [7:0] ZERO_DEFAULT = 8'd11;
  localparam logic [7:0] ZERO_SAT     = 8'hFF;

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Configuration port geometry and register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_MATCH_ID       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_EXTENDED = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNAL_START   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNAL_LENGTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNAL_FORMAT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_OFFSET   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_CONFIRM   = 3'd7;

  // Signal format bits
  localparam int FMT_LITTLE = 0;
  localparam int FMT_SIGNED = 1;

  // Q31.16 bounds and the largest product magnitude that can still fit
  localparam logic signed [47:0] Q_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] Q_MIN = 48'sh8000_0000_0000;
  localparam logic [95:0] PROD_LIMIT = 96'd1 << 49;

  // Input transaction
  typedef struct packed {
    logic [28:0] frame_id;
    logic        frame_extended;
    logic        frame_remote;
    logic [3:0]  frame_length;
    logic [63:0] frame_data;
    logic [31:0] now_ms;
  } cansd_in_t;

  // Result transaction
  typedef struct packed {
    logic               frame_matched;
    logic               decode_ok;
    logic signed [47:0] decoded_value;
    logic               held_valid;
    logic signed [47:0] held_value;
    logic [7:0]         zero_run;
    logic [31:0]        seen_time;
  } cansd_out_t;

  // Configuration registers
  typedef struct packed {
    logic [28:0]        match_id;
    logic               match_extended;
    logic [5:0]         signal_start;
    logic [6:0]         signal_length;
    logic [1:0]         signal_format;
    logic signed [31:0] scale_factor;
    logic signed [47:0] scale_offset;
    logic [7:0]         zero_confirm;
  } cansd_cfg_t;

  // Classified frame handed from front to back
  typedef struct packed {
    logic        matched;
    logic        fit;
    logic        rneg;
    logic [63:0] raw;
    logic [31:0] now_ms;
  } cansd_item_t;

endpackage

`default_nettype wire

// ===== rtl/cansd_front.sv =====
// Front of the CAN signal decoder: frame match, fit check and raw extraction.
// Depends on cansd_pkg; feeds cansd_queue.
`default_nettype none

module cansd_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cansd_pkg::cansd_cfg_t   cfg,
  input  logic                    in_push,
  output logic                    in_full,
  input  cansd_pkg::cansd_in_t    in_item,
  output logic                    q_push,
  input  logic                    q_full,
  output cansd_pkg::cansd_item_t  q_item
);
  import cansd_pkg::*;

  logic              take;
  logic              matched;
  logic [6:0]        payload_bits;
  logic [7:0]        le_end;
  logic [5:0]        be_start;
  logic [7:0]        be_end;
  logic [7:0]        be_shift;
  logic              le_fit;
  logic              be_fit;
  logic [63:0]       swapped;
  logic [63:0]       mask;
  logic [63:0]       field;
  logic [63:0]       raw_m;
  logic              signed_en;
  logic              sign_bit;
  cansd_item_t       item_nxt;
  logic              fr_v_r;
  logic              fr_v_nxt;
  cansd_item_t       fr_item_r;

  // Match on identifier, frame type and length code
  always_comb begin
    matched = !in_item.frame_remote
              && (in_item.frame_length <= 4'(PAYLOAD_BYTES))
              && (in_item.frame_id == cfg.match_id)
              && (in_item.frame_extended == cfg.match_extended);
  end

  // Fit checks; big-endian walks bytes upward, bits downward within a byte
  always_comb begin
    payload_bits = {in_item.frame_length, 3'b000};
    le_end       = {2'b00, cfg.signal_start} + {1'b0, cfg.signal_length};
    be_start     = {cfg.signal_start[5:3], ~cfg.signal_start[2:0]};
    be_end       = {2'b00, be_start} + {1'b0, cfg.signal_length};
    be_shift     = 8'(PAYLOAD_BITS) - be_end;
    le_fit       = le_end <= {1'b0, payload_bits};
    be_fit       = (cfg.signal_length == '0) || (be_end <= {1'b0, payload_bits});
  end

  // Byte-swap so the big-endian walk becomes a plain right shift
  always_comb begin
    for (int b = 0; b < PAYLOAD_BYTES; b++) begin
      swapped[8*b +: 8] = in_item.frame_data[8*(PAYLOAD_BYTES-1-b) +: 8];
    end
  end

  // Extract, mask and sign-extend the raw field
  always_comb begin
    mask      = ~({64{1'b1}} << cfg.signal_length);
    field     = cfg.signal_format[FMT_LITTLE] ? (in_item.frame_data >> cfg.signal_start)
                                              : (swapped >> be_shift);
    raw_m     = field & mask;
    signed_en = cfg.signal_format[FMT_SIGNED] && (cfg.signal_length != '0);
    sign_bit  = raw_m[6'(cfg.signal_length - 7'd1)];

    item_nxt.matched = matched;
    item_nxt.fit     = cfg.signal_format[FMT_LITTLE] ? le_fit : be_fit;
    item_nxt.rneg    = signed_en && sign_bit;
    item_nxt.raw     = (signed_en && sign_bit) ? (raw_m | ~mask) : raw_m;
    item_nxt.now_ms  = in_item.now_ms;
  end

  // Handshake: hold a classified transaction until the queue takes it
  assign in_full = fr_v_r && q_full;
  assign take    = in_push && !in_full;
  assign q_push  = fr_v_r;
  assign q_item  = fr_item_r;

  always_comb begin
    fr_v_nxt = fr_v_r;
    if (take) begin
      fr_v_nxt = 1'b1;
    end else if (fr_v_r && !q_full) begin
      fr_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_v_r <= 1'b0;
    end else begin
      fr_v_r <= fr_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      fr_item_r <= item_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cansd_queue.sv =====
// Short queue of classified frames between front and back.
// Depends on cansd_pkg for the item type and depth.
`default_nettype none

module cansd_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  output logic                    full,
  input  cansd_pkg::cansd_item_t  wdata,
  input  logic                    pop,
  output logic                    valid,
  output cansd_pkg::cansd_item_t  rdata
);
  import cansd_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cansd_item_t       mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic              push_ok;
  logic              pop_ok;

  assign full    = count_r == CNT_W'(QUEUE_DEPTH);
  assign valid   = count_r != '0;
  assign rdata   = mem_r[rd_ptr_r];
  assign push_ok = push && !full;
  assign pop_ok  = pop && valid;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        count_r <= count_r + 1'b1;
      end else if (pop_ok && !push_ok) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Store the pushed transaction
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue occupancy beyond depth");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push_ok && !pop_ok) |=> (count_r == CNT_W'($past(count_r) + 1'b1)))
    else $error("queue occupancy did not grow on push");

endmodule

`default_nettype wire

// ===== rtl/cansd_back.sv =====
// Back of the CAN signal decoder: scaling pipeline, zero filter and result register.
// Depends on cansd_pkg; drains cansd_queue.
`default_nettype none

module cansd_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cansd_pkg::cansd_cfg_t   cfg,
  input  logic                    q_valid,
  input  cansd_pkg::cansd_item_t  q_item,
  output logic                    q_pop,
  output logic                    out_empty,
  input  logic                    out_pop,
  output cansd_pkg::cansd_out_t   out_item
);
  import cansd_pkg::*;

  // Stage advance enables, back to front
  logic adv1, adv2, adv3, adv4, adv5;

  // Stage 1: magnitudes and sign
  logic        s1_v_r, s1_matched_r, s1_ok_r, s1_neg_r;
  logic [63:0] s1_mr_r;
  logic [31:0] s1_mf_r;
  logic [31:0] s1_now_r;
  logic [63:0] mr_nxt;
  logic [31:0] mf_nxt;

  // Stage 2: partial products
  logic        s2_v_r, s2_matched_r, s2_ok_r, s2_neg_r;
  logic [63:0] s2_lo_r, s2_hi_r;
  logic [31:0] s2_now_r;

  // Stage 3: full product magnitude
  logic        s3_v_r, s3_matched_r, s3_ok_r, s3_neg_r, s3_ovf_r;
  logic [49:0] s3_mag_r;
  logic [31:0] s3_now_r;
  logic [95:0] prod;

  // Stage 4: signed sum and saturation
  logic               s4_v_r, s4_matched_r, s4_ok_r;
  logic signed [47:0] s4_val_r;
  logic [31:0]        s4_now_r;
  logic signed [51:0] sp;
  logic signed [51:0] sum;
  logic               in_range;
  logic               ok_nxt;
  logic signed [47:0] val_nxt;

  // Stage 5: filter state and result register
  logic               out_v_r;
  cansd_out_t         out_r;
  cansd_out_t         out_nxt;
  logic [7:0]         zero_cnt_r, zero_cnt_nxt;
  logic signed [47:0] acc_val_r, acc_val_nxt;
  logic               acc_flag_r, acc_flag_nxt;
  logic [31:0]        last_seen_r, last_seen_nxt;
  logic [7:0]         need;
  logic [7:0]         zero_inc;

  assign adv5  = !out_v_r || out_pop;
  assign adv4  = !s4_v_r || adv5;
  assign adv3  = !s3_v_r || adv4;
  assign adv2  = !s2_v_r || adv3;
  assign adv1  = !s1_v_r || adv2;
  assign q_pop = adv1;

  assign out_empty = !out_v_r;
  assign out_item  = out_r;

  // Hold valid bits per stage; drop them as stages drain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (adv1) s1_v_r  <= q_valid;
      if (adv2) s2_v_r  <= s1_v_r;
      if (adv3) s3_v_r  <= s2_v_r;
      if (adv4) s4_v_r  <= s3_v_r;
      if (adv5) out_v_r <= s4_v_r;
    end
  end

  // Stage 1: take magnitudes of raw value and factor
  always_comb begin
    mr_nxt = q_item.rneg ? (~q_item.raw + 64'd1) : q_item.raw;
    mf_nxt = cfg.scale_factor[31] ? (~cfg.scale_factor + 32'd1) : cfg.scale_factor;
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_matched_r <= q_item.matched;
      s1_ok_r      <= q_item.matched && q_item.fit;
      s1_neg_r     <= q_item.rneg ^ cfg.scale_factor[31];
      s1_mr_r      <= mr_nxt;
      s1_mf_r      <= mf_nxt;
      s1_now_r     <= q_item.now_ms;
    end
  end

  // Stage 2: two 32x32 partial products
  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_matched_r <= s1_matched_r;
      s2_ok_r      <= s1_ok_r;
      s2_neg_r     <= s1_neg_r;
      s2_lo_r      <= s1_mr_r[31:0] * s1_mf_r;
      s2_hi_r      <= s1_mr_r[63:32] * s1_mf_r;
      s2_now_r     <= s1_now_r;
    end
  end

  // Stage 3: combine partial products and flag overflow
  assign prod = {s2_hi_r, 32'd0} + {32'd0, s2_lo_r};

  always_ff @(posedge clk) begin
    if (adv3) begin
      s3_matched_r <= s2_matched_r;
      s3_ok_r      <= s2_ok_r;
      s3_neg_r     <= s2_neg_r;
      s3_ovf_r     <= prod > PROD_LIMIT;
      s3_mag_r     <= prod[49:0];
      s3_now_r     <= s2_now_r;
    end
  end

  // Stage 4: apply sign and offset, saturate to Q31.16
  always_comb begin
    sp       = s3_neg_r ? -$signed({2'b00, s3_mag_r}) : $signed({2'b00, s3_mag_r});
    sum      = sp + $signed({{4{cfg.scale_offset[47]}}, cfg.scale_offset});
    in_range = (sum[51:47] == 5'b00000) || (sum[51:47] == 5'b11111);
    ok_nxt   = s3_ok_r && !s3_ovf_r && in_range;
    if (!s3_ok_r) begin
      val_nxt = '0;
    end else if (s3_ovf_r) begin
      val_nxt = s3_neg_r ? Q_MIN : Q_MAX;
    end else if (!in_range) begin
      val_nxt = sum[51] ? Q_MIN : Q_MAX;
    end else begin
      val_nxt = sum[47:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      s4_matched_r <= s3_matched_r;
      s4_ok_r      <= ok_nxt;
      s4_val_r     <= val_nxt;
      s4_now_r     <= s3_now_r;
    end
  end

  // Stage 5: zero confirmation filter and result assembly
  always_comb begin
    need          = (cfg.zero_confirm == '0) ? ZERO_DEFAULT : cfg.zero_confirm;
    zero_inc      = (zero_cnt_r == ZERO_SAT) ? zero_cnt_r : zero_cnt_r + 8'd1;
    zero_cnt_nxt  = zero_cnt_r;
    acc_val_nxt   = acc_val_r;
    acc_flag_nxt  = acc_flag_r;
    last_seen_nxt = last_seen_r;
    if (s4_ok_r) begin
      last_seen_nxt = s4_now_r;
      if (s4_val_r == '0) begin
        zero_cnt_nxt = zero_inc;
        if (zero_inc >= need) begin
          acc_val_nxt  = s4_val_r;
          acc_flag_nxt = 1'b1;
        end
      end else begin
        zero_cnt_nxt = '0;
        acc_val_nxt  = s4_val_r;
        acc_flag_nxt = 1'b1;
      end
    end
    out_nxt.frame_matched = s4_matched_r;
    out_nxt.decode_ok     = s4_ok_r;
    out_nxt.decoded_value = s4_val_r;
    out_nxt.held_valid    = acc_flag_nxt;
    out_nxt.held_value    = acc_val_nxt;
    out_nxt.zero_run      = zero_cnt_nxt;
    out_nxt.seen_time     = last_seen_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_cnt_r  <= '0;
      acc_val_r   <= '0;
      acc_flag_r  <= 1'b0;
      last_seen_r <= '0;
    end else if (adv5 && s4_v_r) begin
      zero_cnt_r  <= zero_cnt_nxt;
      acc_val_r   <= acc_val_nxt;
      acc_flag_r  <= acc_flag_nxt;
      last_seen_r <= last_seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv5 && s4_v_r) begin
      out_r <= out_nxt;
    end
  end

  a_nonzero_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (adv5 && s4_v_r && s4_ok_r && (s4_val_r != '0)) |=> ((zero_cnt_r == '0) && acc_flag_r))
    else $error("nonzero value did not clear zero run or set held value");

  a_held_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    acc_flag_r |=> acc_flag_r)
    else $error("held flag dropped without reset");

  a_unmatched_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (adv5 && s4_v_r && !s4_matched_r) |=> (!out_r.decode_ok && (out_r.decoded_value == '0)))
    else $error("unmatched frame produced a decoded value");

endmodule

`default_nettype wire

// ===== rtl/can_signal_decoder.sv =====
// Top level of the CAN signal decoder: configuration registers, front, queue, back.
// Depends on cansd_pkg, cansd_front, cansd_queue and cansd_back.
`default_nettype none

// One result transaction comes out for every frame pushed in, in order. The block
// accepts one frame per clock while in_full is low and, with pop held high, delivers
// one result per clock. The pace is set by the scaling pipeline in the back, whose
// 64-by-32 multiply is split into two registered 32x32 partial products followed by
// a registered sum and a saturating offset stage. A frame register in the front and
// a two-entry queue let the input side keep accepting while a result waits to be
// popped. Write configuration only while no frame is in flight.
module can_signal_decoder (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_push,
  output logic                                  in_full,
  input  cansd_pkg::cansd_in_t                  in_item,
  output logic                                  out_empty,
  input  logic                                  out_pop,
  output cansd_pkg::cansd_out_t                 out_item,
  input  logic                                  cfg_we,
  input  logic [cansd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cansd_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import cansd_pkg::*;

  cansd_cfg_t  cfg_r;
  logic        q_push;
  logic        q_full;
  cansd_item_t q_wdata;
  logic        q_pop;
  logic        q_valid;
  cansd_item_t q_rdata;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.match_id       <= '0;
      cfg_r.match_extended <= 1'b0;
      cfg_r.signal_start   <= '0;
      cfg_r.signal_length  <= 7'd8;
      cfg_r.signal_format  <= '0;
      cfg_r.scale_factor   <= 32'sd65536;
      cfg_r.scale_offset   <= '0;
      cfg_r.zero_confirm   <= ZERO_DEFAULT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MATCH_ID:       cfg_r.match_id       <= cfg_wdata[28:0];
        REG_MATCH_EXTENDED: cfg_r.match_extended <= cfg_wdata[0];
        REG_SIGNAL_START:   cfg_r.signal_start   <= cfg_wdata[5:0];
        REG_SIGNAL_LENGTH:  cfg_r.signal_length  <= cfg_wdata[6:0];
        REG_SIGNAL_FORMAT:  cfg_r.signal_format  <= cfg_wdata[1:0];
        REG_SCALE_FACTOR:   cfg_r.scale_factor   <= cfg_wdata[31:0];
        REG_SCALE_OFFSET:   cfg_r.scale_offset   <= cfg_wdata[47:0];
        REG_ZERO_CONFIRM:   cfg_r.zero_confirm   <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  cansd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_push (in_push),
    .in_full (in_full),
    .in_item (in_item),
    .q_push  (q_push),
    .q_full  (q_full),
    .q_item  (q_wdata)
  );

  cansd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .full  (q_full),
    .wdata (q_wdata),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  cansd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_item    (q_rdata),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
